// ===== hw/rtl/lrss_pkg.sv =====
`default_nettype none

package lrss_pkg;

  // Input word kinds.
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_ONLINE = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // Polling rates.
  localparam logic [1:0] RATE_FAST   = 2'd0;
  localparam logic [1:0] RATE_NORMAL = 2'd1;
  localparam logic [1:0] RATE_STABLE = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_MIN_NODES    = 3'd0;
  localparam logic [2:0] REG_FAST_DMIN    = 3'd1;
  localparam logic [2:0] REG_NORMAL_DMIN  = 3'd2;
  localparam logic [2:0] REG_NORMAL_DMAX  = 3'd3;
  localparam logic [2:0] REG_STABLE_DMAX  = 3'd4;
  localparam logic [2:0] REG_FAST_INTV    = 3'd5;
  localparam logic [2:0] REG_NORMAL_INTV  = 3'd6;
  localparam logic [2:0] REG_STABLE_INTV  = 3'd7;

  // Ticks in one state-check period.
  localparam logic [3:0] CHECK_PERIOD = 4'd10;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SR_ADDR,
    ST_SR_CMP,
    ST_SR_NEW,
    ST_EV_INIT,
    ST_EV_LADDR,
    ST_EV_META,
    ST_EV_RADDR,
    ST_EV_RDAT,
    ST_EV_DONE,
    ST_FINISH
  } lrss_state_t;

  typedef struct packed {
    logic load;
    logic srch_next;
    logic hit_wr;
    logic new_wr;
    logic ev_init;
    logic ev_meta;
    logic ev_data;
    logic ev_done;
    logic out_load;
  } lrss_cmd_t;

  typedef struct packed {
    logic at_end;
    logic match;
    logic eob;
    logic few_links;
    logic last_j;
    logic out_free;
  } lrss_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lrss_in_if.sv =====
`default_nettype none

interface lrss_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [7:0]        node_a;
  logic [7:0]        node_b;
  logic signed [7:0] rssi_first;
  logic signed [7:0] rssi_second;
  logic              end_of_batch;
  logic [5:0]        online_count;

  modport source (output valid, kind, node_a, node_b, rssi_first, rssi_second,
                  end_of_batch, online_count, input ready);
  modport sink (input valid, kind, node_a, node_b, rssi_first, rssi_second,
                end_of_batch, online_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lrss_out_if.sv =====
`default_nettype none

interface lrss_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] rate;
  logic       execute_pulse;
  logic       state_check_pulse;
  logic       sample_dropped;
  logic [7:0] spread;

  modport source (output valid, rate, execute_pulse, state_check_pulse, sample_dropped,
                  spread, input ready);
  modport sink (input valid, rate, execute_pulse, state_check_pulse, sample_dropped,
                spread, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lrss_cfg_if.sv =====
`default_nettype none

interface lrss_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/link_rssi_stability_rate_selector_core.sv =====
`default_nettype none

// A tick or an unknown word goes straight to the result register, loaded once the output is
// free. A link sample searches the stored links in turn, then writes a hit's ring or adds a
// new link, and runs an evaluation when it ends a batch; an online-count word always runs
// one. An evaluation walks every ring entry of every link through the ring memory, unless
// too few links are stored. One word is in flight at a time, and the next is taken the
// cycle after the result is loaded. Reset (synchronous, rst_n low) restores the register
// defaults and empties the link table; memories need no clearing pass.

module link_rssi_stability_rate_selector_core
  import lrss_pkg::*;
#(
  parameter int MAX_LINKS  = 32,
  parameter int WINDOW_LEN = 6
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lrss_in_if.sink     in_ch,
  lrss_out_if.source  out_ch,
  lrss_cfg_if.sink    cfg_ch
);

  lrss_cmd_t  cmd;
  lrss_stat_t stat;

  // Configuration writes are always taken, unchecked; the user must send them only while idle.
  assign cfg_ch.ready = 1'b1;

  // The controller sequences the link search and the spread walk.
  lrss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.kind),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (in_ch.ready)
  );

  // The datapath holds the link table, the rings, the counters and the result register.
  lrss_datapath #(
    .MAX_LINKS  (MAX_LINKS),
    .WINDOW_LEN (WINDOW_LEN)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .in_kind               (in_ch.kind),
    .in_node_a             (in_ch.node_a),
    .in_node_b             (in_ch.node_b),
    .in_rssi_first         (in_ch.rssi_first),
    .in_rssi_second        (in_ch.rssi_second),
    .in_end_of_batch       (in_ch.end_of_batch),
    .in_online_count       (in_ch.online_count),
    .cfg_we                (cfg_ch.valid),
    .cfg_index             (cfg_ch.index),
    .cfg_data              (cfg_ch.data),
    .out_ready             (out_ch.ready),
    .out_valid             (out_ch.valid),
    .out_rate              (out_ch.rate),
    .out_execute_pulse     (out_ch.execute_pulse),
    .out_state_check_pulse (out_ch.state_check_pulse),
    .out_sample_dropped    (out_ch.sample_dropped),
    .out_spread            (out_ch.spread)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/lrss_ctrl.sv =====
`default_nettype none

module lrss_ctrl
  import lrss_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_kind,
  input  wire lrss_stat_t stat,
  output lrss_cmd_t       cmd,
  output logic            in_ready
);

  lrss_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            KIND_SAMPLE: state_nxt = ST_SR_ADDR;
            KIND_ONLINE: state_nxt = ST_EV_INIT;
            default:     state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_SR_ADDR:  state_nxt = stat.at_end ? ST_SR_NEW : ST_SR_CMP;
      ST_SR_CMP: begin
        if (stat.match) begin
          state_nxt = stat.eob ? ST_EV_INIT : ST_FINISH;
        end else begin
          state_nxt = ST_SR_ADDR;
        end
      end
      ST_SR_NEW:   state_nxt = stat.eob ? ST_EV_INIT : ST_FINISH;
      ST_EV_INIT:  state_nxt = stat.few_links ? ST_EV_DONE : ST_EV_LADDR;
      ST_EV_LADDR: state_nxt = stat.at_end ? ST_EV_DONE : ST_EV_META;
      ST_EV_META:  state_nxt = ST_EV_RADDR;
      ST_EV_RADDR: state_nxt = ST_EV_RDAT;
      ST_EV_RDAT:  state_nxt = stat.last_j ? ST_EV_LADDR : ST_EV_RADDR;
      ST_EV_DONE:  state_nxt = ST_FINISH;
      ST_FINISH:   state_nxt = stat.out_free ? ST_IDLE : ST_FINISH;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SR_CMP: begin
        cmd.hit_wr    = stat.match;
        cmd.srch_next = !stat.match;
      end
      ST_SR_NEW:   cmd.new_wr   = 1'b1;
      ST_EV_INIT:  cmd.ev_init  = 1'b1;
      ST_EV_META:  cmd.ev_meta  = 1'b1;
      ST_EV_RDAT:  cmd.ev_data  = 1'b1;
      ST_EV_DONE:  cmd.ev_done  = 1'b1;
      ST_FINISH:   cmd.out_load = stat.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lrss_datapath.sv =====
`default_nettype none

module lrss_datapath
  import lrss_pkg::*;
#(
  parameter int MAX_LINKS  = 32,
  parameter int WINDOW_LEN = 6
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lrss_cmd_t         cmd,
  output lrss_stat_t             stat,
  input  wire logic [1:0]        in_kind,
  input  wire logic [7:0]        in_node_a,
  input  wire logic [7:0]        in_node_b,
  input  wire logic signed [7:0] in_rssi_first,
  input  wire logic signed [7:0] in_rssi_second,
  input  wire logic              in_end_of_batch,
  input  wire logic [5:0]        in_online_count,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [7:0]        cfg_data,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [1:0]             out_rate,
  output logic                   out_execute_pulse,
  output logic                   out_state_check_pulse,
  output logic                   out_sample_dropped,
  output logic [7:0]             out_spread
);

  localparam int IW   = $clog2(MAX_LINKS);
  localparam int LCW  = $clog2(MAX_LINKS + 1);
  localparam int RAW  = $clog2(MAX_LINKS * WINDOW_LEN);
  localparam int JW   = $clog2(WINDOW_LEN);
  localparam logic [RAW-1:0] WIN_STEP = RAW'(WINDOW_LEN);
  localparam logic [JW-1:0]  J_LAST   = JW'(WINDOW_LEN - 1);
  localparam logic [LCW-1:0] LC_MAX   = LCW'(MAX_LINKS);

  // Configuration registers.
  logic [5:0] min_nodes_r;
  logic [7:0] fast_dmin_r, normal_dmin_r, normal_dmax_r, stable_dmax_r;
  logic [7:0] fast_intv_r, normal_intv_r, stable_intv_r;

  // Captured word.
  logic [7:0]        a_r, b_r;
  logic signed [7:0] avg_r;
  logic              eob_r;

  // Block state.
  logic [LCW-1:0] link_count_r;
  logic [1:0]     rate_r;
  logic [5:0]     online_r;
  logic [7:0]     exec_el_r;
  logic [3:0]     chk_el_r;
  logic [7:0]     spread_r;

  // Walk state.
  logic [LCW-1:0] idx_r;
  logic [RAW-1:0] base_r;
  logic [JW-1:0]  j_r;
  logic [JW-1:0]  pos_r;
  logic           full_r;
  logic [7:0]     hi_r, lo_r, worst_r;
  logic           zero_r;
  logic           dropped_r, exec_p_r, chk_p_r;

  // Memories with registered reads.
  logic [15:0]   node_mem [MAX_LINKS];
  logic [JW:0]   meta_mem [MAX_LINKS];
  logic [7:0]    ring_mem [MAX_LINKS * WINDOW_LEN];
  logic [15:0]   node_q_r;
  logic [JW:0]   meta_q_r;
  logic [7:0]    ring_q_r;

  logic [IW-1:0]  rd_idx;
  logic [RAW-1:0] ring_rd_addr;
  logic [RAW-1:0] ring_wr_addr;
  logic [7:0]     ring_wr_data;
  logic           ring_we;
  logic [JW:0]    meta_wr_data;
  logic           meta_we;
  logic [IW-1:0]  wr_idx;

  assign rd_idx       = idx_r[IW-1:0];
  assign ring_rd_addr = base_r + RAW'(j_r);

  // Averaging of the two readings, truncated toward zero.
  logic signed [8:0] rssi_sum;
  logic [8:0]        rssi_adj;
  assign rssi_sum = 9'(in_rssi_first) + 9'(in_rssi_second);
  assign rssi_adj = rssi_sum + {8'd0, rssi_sum[8]};

  // Pair match, either order.
  logic match;
  assign match = (node_q_r[15:8] == a_r && node_q_r[7:0] == b_r) ||
                 (node_q_r[15:8] == b_r && node_q_r[7:0] == a_r);

  // Ring update on a hit.
  logic [JW-1:0] hit_pos, hit_pos_nxt;
  logic          hit_full;
  assign hit_pos     = meta_q_r[JW-1:0];
  assign hit_pos_nxt = (hit_pos >= J_LAST) ? '0 : hit_pos + JW'(1);
  assign hit_full    = meta_q_r[JW] || (hit_pos >= J_LAST);

  always_comb begin
    ring_we      = 1'b0;
    meta_we      = 1'b0;
    ring_wr_addr = base_r;
    ring_wr_data = avg_r;
    meta_wr_data = {1'b0, JW'(1)};
    wr_idx       = rd_idx;
    if (cmd.hit_wr) begin
      ring_we      = 1'b1;
      meta_we      = 1'b1;
      ring_wr_addr = base_r + RAW'(hit_pos);
      meta_wr_data = {hit_full, hit_pos_nxt};
    end else if (cmd.new_wr && link_count_r != LC_MAX) begin
      ring_we = 1'b1;
      meta_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.new_wr && link_count_r != LC_MAX) begin
      node_mem[wr_idx] <= {a_r, b_r};
    end
    if (meta_we) begin
      meta_mem[wr_idx] <= meta_wr_data;
    end
    node_q_r <= node_mem[rd_idx];
    meta_q_r <= meta_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_wr_addr] <= ring_wr_data;
    end
    ring_q_r <= ring_mem[ring_rd_addr];
  end

  // Spread walk: an entry never written reads as empty.
  logic       entry_ok;
  logic [7:0] entry_val, entry_abs, hi_nxt, lo_nxt, link_spread;
  assign entry_ok    = full_r || (j_r < pos_r);
  assign entry_val   = entry_ok ? ring_q_r : 8'd0;
  assign entry_abs   = entry_val[7] ? (~entry_val + 8'd1) : entry_val;
  assign hi_nxt      = (j_r == '0 || entry_abs > hi_r) ? entry_abs : hi_r;
  assign lo_nxt      = (j_r == '0 || entry_abs < lo_r) ? entry_abs : lo_r;
  assign link_spread = hi_nxt - lo_nxt;

  logic few_links;
  assign few_links = 16'(link_count_r) < 16'(min_nodes_r);

  // Final rate selection.
  logic [1:0] stab_rate, mesh_rate, new_rate;
  logic       stab_fast;
  assign stab_fast = few_links || zero_r;
  always_comb begin
    if (stab_fast || worst_r >= fast_dmin_r) begin
      stab_rate = RATE_FAST;
    end else if (worst_r >= normal_dmin_r && worst_r <= normal_dmax_r) begin
      stab_rate = RATE_NORMAL;
    end else if (worst_r <= stable_dmax_r) begin
      stab_rate = RATE_STABLE;
    end else begin
      stab_rate = RATE_FAST;
    end
  end
  assign mesh_rate = (online_r < min_nodes_r) ? RATE_FAST : RATE_STABLE;
  assign new_rate  = (stab_rate < mesh_rate) ? stab_rate : mesh_rate;

  // Tick counters.
  logic [3:0] chk_inc;
  logic [7:0] exec_inc, cur_intv;
  logic       chk_hit, exec_hit;
  assign chk_inc  = chk_el_r + 4'd1;
  assign chk_hit  = chk_inc >= CHECK_PERIOD;
  assign exec_inc = (exec_el_r == 8'hFF) ? exec_el_r : exec_el_r + 8'd1;
  always_comb begin
    case (rate_r)
      RATE_NORMAL: cur_intv = normal_intv_r;
      RATE_STABLE: cur_intv = stable_intv_r;
      default:     cur_intv = fast_intv_r;
    endcase
  end
  assign exec_hit = (online_r >= min_nodes_r) && (exec_inc >= cur_intv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_nodes_r   <= 6'd3;
      fast_dmin_r   <= 8'd5;
      normal_dmin_r <= 8'd3;
      normal_dmax_r <= 8'd4;
      stable_dmax_r <= 8'd2;
      fast_intv_r   <= 8'd5;
      normal_intv_r <= 8'd8;
      stable_intv_r <= 8'd20;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_NODES:   min_nodes_r   <= cfg_data[5:0];
        REG_FAST_DMIN:   fast_dmin_r   <= cfg_data;
        REG_NORMAL_DMIN: normal_dmin_r <= cfg_data;
        REG_NORMAL_DMAX: normal_dmax_r <= cfg_data;
        REG_STABLE_DMAX: stable_dmax_r <= cfg_data;
        REG_FAST_INTV:   fast_intv_r   <= cfg_data;
        REG_NORMAL_INTV: normal_intv_r <= cfg_data;
        REG_STABLE_INTV: stable_intv_r <= cfg_data;
        default: begin
          fast_intv_r <= fast_intv_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_count_r <= '0;
      rate_r       <= RATE_FAST;
      online_r     <= '0;
      exec_el_r    <= '0;
      chk_el_r     <= '0;
      spread_r     <= '0;
      dropped_r    <= 1'b0;
      exec_p_r     <= 1'b0;
      chk_p_r      <= 1'b0;
      idx_r        <= '0;
      base_r       <= '0;
      j_r          <= '0;
      zero_r       <= 1'b0;
      worst_r      <= '0;
    end else begin
      if (cmd.load) begin
        a_r       <= in_node_a;
        b_r       <= in_node_b;
        avg_r     <= rssi_adj[8:1];
        eob_r     <= in_end_of_batch;
        idx_r     <= '0;
        base_r    <= '0;
        dropped_r <= 1'b0;
        exec_p_r  <= 1'b0;
        chk_p_r   <= 1'b0;
        if (in_kind == KIND_ONLINE) begin
          online_r <= in_online_count;
        end
        if (in_kind == KIND_TICK) begin
          chk_p_r   <= chk_hit;
          chk_el_r  <= chk_hit ? 4'd0 : chk_inc;
          exec_p_r  <= exec_hit;
          exec_el_r <= exec_hit ? 8'd0 : exec_inc;
        end
      end
      if (cmd.srch_next) begin
        idx_r  <= idx_r + LCW'(1);
        base_r <= base_r + WIN_STEP;
      end
      if (cmd.new_wr) begin
        if (link_count_r == LC_MAX) begin
          dropped_r <= 1'b1;
        end else begin
          link_count_r <= link_count_r + LCW'(1);
        end
      end
      if (cmd.ev_init) begin
        idx_r   <= '0;
        base_r  <= '0;
        worst_r <= '0;
        zero_r  <= 1'b0;
      end
      if (cmd.ev_meta) begin
        pos_r  <= meta_q_r[JW-1:0];
        full_r <= meta_q_r[JW];
        j_r    <= '0;
      end
      if (cmd.ev_data) begin
        hi_r <= hi_nxt;
        lo_r <= lo_nxt;
        if (entry_val == 8'd0) begin
          zero_r <= 1'b1;
        end
        if (j_r == J_LAST) begin
          if (link_spread > worst_r) begin
            worst_r <= link_spread;
          end
          idx_r  <= idx_r + LCW'(1);
          base_r <= base_r + WIN_STEP;
        end else begin
          j_r <= j_r + JW'(1);
        end
      end
      if (cmd.ev_done) begin
        rate_r   <= new_rate;
        spread_r <= stab_fast ? 8'd0 : worst_r;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_rate              <= rate_r;
      out_execute_pulse     <= exec_p_r;
      out_state_check_pulse <= chk_p_r;
      out_sample_dropped    <= dropped_r;
      out_spread            <= spread_r;
    end
  end

  assign stat.at_end    = (idx_r == link_count_r);
  assign stat.match     = match;
  assign stat.eob       = eob_r;
  assign stat.few_links = few_links;
  assign stat.last_j    = (j_r == J_LAST);
  assign stat.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire

// ===== sim/link_rssi_stability_rate_selector_core_tb.sv =====
`timescale 1ns / 100ps

module link_rssi_stability_rate_selector_core_tb;
  import lrss_pkg::*;

  localparam int LINKS_MAX = 32;
  localparam int RING_LEN  = 6;
  localparam int FAST_TOP  = 1000;

  // One input word as the sender builds it.
  typedef struct {
    logic [1:0]        kind;
    logic [7:0]        node_a;
    logic [7:0]        node_b;
    logic signed [7:0] rssi_first;
    logic signed [7:0] rssi_second;
    logic              end_of_batch;
    logic [5:0]        online_count;
  } lrss_word_t;

  // One result word as the block should return it.
  typedef struct packed {
    logic [1:0] rate;
    logic       execute_pulse;
    logic       state_check_pulse;
    logic       sample_dropped;
    logic [7:0] spread;
  } rate_result_t;

  logic clk;
  logic rst_n;

  lrss_in_if  in_ch ();
  lrss_out_if out_ch ();
  lrss_cfg_if cfg_ch ();

  link_rssi_stability_rate_selector_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // The clock runs with a 10 ns period.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Shadow copy of the block: its registers, its link table and its rate state.
  int unsigned reg_file [8];
  logic [7:0]  shadow_first [LINKS_MAX];
  logic [7:0]  shadow_second [LINKS_MAX];
  int          shadow_ring [LINKS_MAX * RING_LEN];
  int          shadow_pos [LINKS_MAX];
  int unsigned shadow_links;
  logic [1:0]  shadow_rate;
  int unsigned shadow_online;
  int unsigned shadow_exec_ticks;
  int unsigned shadow_check_ticks;
  int unsigned shadow_spread;

  rate_result_t pending_results [$];
  int unsigned  error_count;

  // Switches shared by the sender, the receiver and the test tasks.
  bit no_idle;
  bit hold_receiver;

  // Knobs for the random word maker; the tests that use it set them to steer the stimulus.
  logic [7:0] id_mask;
  int         id_pool;
  int         rssi_base;
  int         rssi_jitter;

  // The stability term: Fast while too few links exist or any ring has an empty
  // entry, otherwise the band that holds the worst spread of absolute values.
  function automatic logic [1:0] stability_term();
    int unsigned worst;
    int unsigned hi;
    int unsigned lo;
    int unsigned mag;
    worst = 0;
    shadow_spread = 0;
    if (shadow_links < reg_file[REG_MIN_NODES]) return RATE_FAST;
    for (int i = 0; i < shadow_links; i++)
      for (int j = 0; j < RING_LEN; j++)
        if (shadow_ring[i * RING_LEN + j] == 0) return RATE_FAST;
    for (int i = 0; i < shadow_links; i++) begin
      hi = (shadow_ring[i * RING_LEN] < 0) ? -shadow_ring[i * RING_LEN]
                                           : shadow_ring[i * RING_LEN];
      lo = hi;
      for (int j = 1; j < RING_LEN; j++) begin
        mag = (shadow_ring[i * RING_LEN + j] < 0) ? -shadow_ring[i * RING_LEN + j]
                                                  : shadow_ring[i * RING_LEN + j];
        if (mag > hi) hi = mag;
        if (mag < lo) lo = mag;
      end
      if (hi - lo > worst) worst = hi - lo;
    end
    shadow_spread = worst & 8'hFF;
    if (worst >= reg_file[REG_FAST_DMIN] && worst <= FAST_TOP) return RATE_FAST;
    if (worst >= reg_file[REG_NORMAL_DMIN] && worst <= reg_file[REG_NORMAL_DMAX])
      return RATE_NORMAL;
    if (worst <= reg_file[REG_STABLE_DMAX]) return RATE_STABLE;
    return RATE_FAST;
  endfunction

  // The rate is the faster of the mesh term and the stability term.
  function automatic void reevaluate_rate();
    logic [1:0] mesh;
    logic [1:0] stab;
    mesh = (shadow_online < reg_file[REG_MIN_NODES]) ? RATE_FAST : RATE_STABLE;
    stab = stability_term();
    shadow_rate = (stab < mesh) ? stab : mesh;
  endfunction

  // Stores one averaged sample; returns 1 when a new pair finds the table full.
  function automatic bit store_sample(logic [7:0] a, logic [7:0] b, int avg);
    int p;
    for (int i = 0; i < shadow_links; i++) begin
      if ((shadow_first[i] == a && shadow_second[i] == b) ||
          (shadow_first[i] == b && shadow_second[i] == a)) begin
        p = (shadow_pos[i] >= RING_LEN) ? 0 : shadow_pos[i];
        shadow_ring[i * RING_LEN + p] = avg;
        shadow_pos[i] = (p >= RING_LEN - 1) ? 0 : p + 1;
        return 1'b0;
      end
    end
    if (shadow_links >= LINKS_MAX) return 1'b1;
    shadow_first[shadow_links] = a;
    shadow_second[shadow_links] = b;
    shadow_ring[shadow_links * RING_LEN] = avg;
    shadow_pos[shadow_links] = 1 % RING_LEN;
    shadow_links++;
    return 1'b0;
  endfunction

  // Advances the shadow copy by one accepted word and returns the result it causes.
  function automatic rate_result_t predict_rate_result(lrss_word_t w);
    rate_result_t r;
    int unsigned  intv;
    int           avg;
    r = '0;
    if (w.kind == KIND_SAMPLE) begin
      // Integer division truncates toward zero, as the block does.
      avg = (int'(w.rssi_first) + int'(w.rssi_second)) / 2;
      r.sample_dropped = store_sample(w.node_a, w.node_b, avg);
      if (w.end_of_batch) reevaluate_rate();
    end else if (w.kind == KIND_ONLINE) begin
      shadow_online = w.online_count;
      reevaluate_rate();
    end else if (w.kind == KIND_TICK) begin
      shadow_check_ticks++;
      if (shadow_check_ticks >= CHECK_PERIOD) begin
        r.state_check_pulse = 1'b1;
        shadow_check_ticks = 0;
      end
      if (shadow_exec_ticks < 255) shadow_exec_ticks++;
      case (shadow_rate)
        RATE_NORMAL: intv = reg_file[REG_NORMAL_INTV];
        RATE_STABLE: intv = reg_file[REG_STABLE_INTV];
        default:     intv = reg_file[REG_FAST_INTV];
      endcase
      if (shadow_online >= reg_file[REG_MIN_NODES] && shadow_exec_ticks >= intv) begin
        r.execute_pulse = 1'b1;
        shadow_exec_ticks = 0;
      end
    end
    r.rate = shadow_rate;
    r.spread = shadow_spread[7:0];
    return r;
  endfunction

  // Sends one word. The valid line is left high after acceptance so that a word
  // which follows at once needs no second assignment in the same time step.
  task automatic send_word(lrss_word_t w);
    if (!no_idle && ($urandom % 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= w.kind;
    in_ch.node_a       <= w.node_a;
    in_ch.node_b       <= w.node_b;
    in_ch.rssi_first   <= w.rssi_first;
    in_ch.rssi_second  <= w.rssi_second;
    in_ch.end_of_batch <= w.end_of_batch;
    in_ch.online_count <= w.online_count;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_rate_result(w));
  endtask

  // Lowers the input and waits until every expected result word has arrived.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Writes one register while the block is idle.
  task automatic write_reg(logic [2:0] idx, logic [7:0] value);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    reg_file[idx] = (idx == REG_MIN_NODES) ? (value & 8'h3F) : value;
    @(posedge clk);
  endtask

  task automatic load_settings(int mn, int fdmin, int ndmin, int ndmax, int sdmax,
                               int fi, int ni, int si);
    write_reg(REG_MIN_NODES, mn);
    write_reg(REG_FAST_DMIN, fdmin);
    write_reg(REG_NORMAL_DMIN, ndmin);
    write_reg(REG_NORMAL_DMAX, ndmax);
    write_reg(REG_STABLE_DMAX, sdmax);
    write_reg(REG_FAST_INTV, fi);
    write_reg(REG_NORMAL_INTV, ni);
    write_reg(REG_STABLE_INTV, si);
  endtask

  function automatic lrss_word_t make_word(logic [1:0] kind, logic [7:0] a, logic [7:0] b,
                                           int r1, int r2, bit eob, int cnt);
    lrss_word_t w;
    w.kind = kind;
    w.node_a = a;
    w.node_b = b;
    w.rssi_first = r1;
    w.rssi_second = r2;
    w.end_of_batch = eob;
    w.online_count = cnt;
    return w;
  endfunction

  function automatic int clamp_rssi(int v);
    return (v > 127) ? 127 : ((v < -128) ? -128 : v);
  endfunction

  // Random word. Most samples revisit known links with readings close to a base
  // level, so that rings fill and the stable bands are reached; the rest is noise.
  function automatic lrss_word_t random_word();
    lrss_word_t w;
    int sel;
    int k;
    int v;
    w = make_word(KIND_SAMPLE, 0, 0, 0, 0, 0, 0);
    w.online_count = $urandom;
    w.node_a = $urandom;
    w.node_b = $urandom;
    sel = $urandom % 100;
    if (sel < 55) begin
      if (shadow_links != 0 && ($urandom % 100) < 70) begin
        k = $urandom % shadow_links;
        w.node_a = ($urandom % 2) ? shadow_first[k] : shadow_second[k];
        w.node_b = (w.node_a == shadow_first[k]) ? shadow_second[k] : shadow_first[k];
      end else begin
        w.node_a = $urandom_range(0, id_pool - 1) ^ id_mask;
        w.node_b = $urandom_range(0, id_pool - 1) ^ id_mask;
      end
      if (($urandom % 10) == 0) begin
        w.rssi_first = $urandom;
        w.rssi_second = $urandom;
      end else begin
        v = clamp_rssi(rssi_base + $urandom_range(0, rssi_jitter));
        w.rssi_first = v;
        w.rssi_second = clamp_rssi(v + $urandom_range(0, 1));
      end
      w.end_of_batch = ($urandom % 3) == 0;
    end else if (sel < 80) begin
      w.kind = KIND_TICK;
    end else if (sel < 93) begin
      w.kind = KIND_ONLINE;
      if (($urandom % 4) != 0) w.online_count = reg_file[REG_MIN_NODES] + $urandom_range(0, 3);
    end else begin
      w.kind = 2'd3;
    end
    return w;
  endfunction

  task automatic send_random(int count);
    repeat (count) send_word(random_word());
  endtask

  // Receiver: ready toggles in random bursts, holds off for a long stretch when
  // asked, and stays high through the closing part of the run.
  initial begin
    int len;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_receiver) begin
        out_ch.ready <= 1'b0;
        len = 0;
        while (len < 600) begin
          @(posedge clk);
          len++;
        end
        hold_receiver = 1'b0;
      end else if (no_idle) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ch.ready <= (($urandom % 3) != 0);
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  // Every accepted result word is checked against the oldest expectation.
  always @(posedge clk) begin
    rate_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word rate=%0d", $time, out_ch.rate);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.rate !== want.rate) begin
          $display("%0t: rate expected %0d actual %0d", $time, want.rate, out_ch.rate);
          error_count++;
        end
        if (out_ch.execute_pulse !== want.execute_pulse) begin
          $display("%0t: execute_pulse expected %0d actual %0d", $time,
                   want.execute_pulse, out_ch.execute_pulse);
          error_count++;
        end
        if (out_ch.state_check_pulse !== want.state_check_pulse) begin
          $display("%0t: state_check_pulse expected %0d actual %0d", $time,
                   want.state_check_pulse, out_ch.state_check_pulse);
          error_count++;
        end
        if (out_ch.sample_dropped !== want.sample_dropped) begin
          $display("%0t: sample_dropped expected %0d actual %0d", $time,
                   want.sample_dropped, out_ch.sample_dropped);
          error_count++;
        end
        if (out_ch.spread !== want.spread) begin
          $display("%0t: spread expected %0d actual %0d", $time, want.spread, out_ch.spread);
          error_count++;
        end
      end
    end
  end

  // Extremes of the fields, every kind, swapped pairs, zero averages and the
  // unknown kind, all from the reset settings.
  task automatic test_directed();
    send_word(make_word(2'd3, 8'hFF, 8'h00, -128, 127, 1, 63));
    send_word(make_word(KIND_TICK, 0, 0, 0, 0, 0, 0));
    send_word(make_word(KIND_ONLINE, 0, 0, 0, 0, 0, 0));
    send_word(make_word(KIND_ONLINE, 0, 0, 0, 0, 0, 63));
    send_word(make_word(KIND_SAMPLE, 8'h00, 8'hFF, -128, -128, 1, 0));
    send_word(make_word(KIND_SAMPLE, 8'hFF, 8'h00, 127, 127, 0, 0));
    // A sum of -1 truncates to a zero average, which reads as an empty entry.
    send_word(make_word(KIND_SAMPLE, 8'h00, 8'hFF, -128, 127, 1, 0));
    send_word(make_word(KIND_SAMPLE, 8'h12, 8'h12, -3, -4, 0, 0));
    send_word(make_word(KIND_SAMPLE, 8'h12, 8'h34, 0, 0, 1, 0));
    for (int i = 0; i < 6; i++) begin
      send_word(make_word(KIND_SAMPLE, 8'h00, 8'hFF, -50, -50 - i, 0, 0));
      send_word(make_word(KIND_SAMPLE, 8'h12, 8'h12, -40, -40, 0, 0));
    end
    send_word(make_word(KIND_SAMPLE, 8'h34, 8'h12, -61, -61, 1, 0));
    send_word(make_word(KIND_ONLINE, 0, 0, 0, 0, 0, 3));
    repeat (6) send_word(make_word(KIND_TICK, 0, 0, 0, 0, 0, 0));
  endtask

  // Random words under the reset settings.
  task automatic test_reset_settings();
    id_mask = 8'h00;
    id_pool = 4;
    rssi_base = -60;
    rssi_jitter = 3;
    send_random(250);
  endtask

  // Several settings, the lowest and highest values among them.
  task automatic test_settings_sweep();
    load_settings(1, 0, 0, 0, 0, 1, 1, 1);
    rssi_jitter = 0;
    send_random(150);
    load_settings(32, 255, 255, 255, 255, 255, 255, 255);
    id_mask = 8'hFF;
    rssi_base = 90;
    rssi_jitter = 2;
    send_random(150);
    load_settings(2, 200, 0, 255, 255, 1, 2, 3);
    send_random(150);
    for (int s = 0; s < 4; s++) begin
      load_settings($urandom_range(1, 6), $urandom_range(2, 8), $urandom_range(0, 3),
                    $urandom_range(2, 6), $urandom_range(0, 3), $urandom_range(1, 12),
                    $urandom_range(1, 12), $urandom_range(1, 30));
      id_mask = (s % 2) ? 8'hFF : 8'h00;
      rssi_base = $urandom_range(0, 255) - 128;
      rssi_jitter = $urandom_range(0, 6);
      send_random(140);
    end
  endtask

  // The receiver stalls for a long time while words keep being offered.
  task automatic test_receiver_stall();
    load_settings(3, 5, 3, 4, 2, 5, 8, 20);
    hold_receiver = 1'b1;
    send_random(80);
  endtask

  // The sender stops until every expected result has come back.
  task automatic test_sender_pause();
    send_random(40);
    drain_results();
    send_random(40);
  endtask

  // More distinct pairs than the table holds, then samples of wide ids that are
  // mostly dropped, mixed with refills of the links already stored.
  task automatic test_table_full();
    load_settings(4, 9, 4, 8, 3, 2, 3, 4);
    for (int i = 0; i < 36; i++)
      send_word(make_word(KIND_SAMPLE, 8'h40 + i, 8'h80 + i, -70, -71, i == 35, 0));
    id_mask = 8'h00;
    id_pool = 256;
    rssi_base = -75;
    rssi_jitter = 4;
    send_random(300);
  endtask

  // The closing stretch runs with no idling on either side.
  task automatic test_no_idle();
    no_idle = 1'b1;
    send_random(200);
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_SAMPLE;
    in_ch.node_a = '0;
    in_ch.node_b = '0;
    in_ch.rssi_first = '0;
    in_ch.rssi_second = '0;
    in_ch.end_of_batch = 1'b0;
    in_ch.online_count = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    error_count = 0;
    no_idle = 1'b0;
    hold_receiver = 1'b0;
    id_mask = 8'h00;
    id_pool = 4;
    rssi_base = -60;
    rssi_jitter = 3;

    // Reset values of the shadow copy follow those of the block.
    reg_file = '{3, 5, 3, 4, 2, 5, 8, 20};
    for (int i = 0; i < LINKS_MAX; i++) begin
      shadow_first[i] = '0;
      shadow_second[i] = '0;
      shadow_pos[i] = 0;
    end
    for (int i = 0; i < LINKS_MAX * RING_LEN; i++) shadow_ring[i] = 0;
    shadow_links = 0;
    shadow_rate = RATE_FAST;
    shadow_online = 0;
    shadow_exec_ticks = 0;
    shadow_check_ticks = 0;
    shadow_spread = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_reset_settings();
    test_settings_sweep();
    test_receiver_stall();
    test_sender_pause();
    test_table_full();
    test_no_idle();

    // Let the last words come out, then allow for a full evaluation more.
    drain_results();
    repeat (500) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #60000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
